[design/givens_rotation_generate_unit_defines.svh]
// Assertion macros for the Givens rotation generator.
// Used by the top level; depends on a clock named clk and a reset named rst.
`ifndef GIVENS_ROTATION_GENERATE_UNIT_DEFINES_SVH
`define GIVENS_ROTATION_GENERATE_UNIT_DEFINES_SVH

// Implication checked outside reset.
`define GRG_ASSERT_IMPL(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) else $error(msg);

// Property checked at every edge, reset included.
`define GRG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/grg_pkg.sv]
// Shared types and constants of the Givens rotation generator.
// No dependencies.
`timescale 1ns / 1ps

package grg_pkg;

  localparam int FIELD_W       = 32;
  localparam int IN_WIDTH_DEF  = 32;
  localparam int FRAC_BITS_DEF = 30;

  // Control that travels alongside each item through the pipeline.
  typedef struct packed {
    logic valid;
    logic zero;
    logic c_neg;
    logic s_neg;
  } ctl_t;

endpackage

[design/grg_front.sv]
// Front end of the Givens rotation generator: magnitudes, signs, squares and sum.
// Depends on grg_pkg.
`timescale 1ns / 1ps

module grg_front import grg_pkg::*; #(
  parameter int IN_WIDTH  = IN_WIDTH_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   take,
  input  logic [FIELD_W-1:0]                     in_a,
  input  logic [FIELD_W-1:0]                     in_b,
  output ctl_t                                   ctl,
  output logic [2*IN_WIDTH-1:0]                  sum,
  output logic [2*IN_WIDTH+2*FRAC_BITS+1:0]      rem_c,
  output logic [2*IN_WIDTH+2*FRAC_BITS+1:0]      rem_s
);

  localparam int SW = 2 * IN_WIDTH;
  localparam int RW = SW + 2 * FRAC_BITS + 2;

  logic [IN_WIDTH-1:0] a_raw, b_raw, a_abs, b_abs;
  logic                a_neg, b_neg, r_neg;
  logic [IN_WIDTH-1:0] a_mag, b_mag;
  logic [SW-1:0]       a_sq, b_sq;
  ctl_t                ctl1, ctl2;

  assign a_raw = in_a[IN_WIDTH-1:0];
  assign b_raw = in_b[IN_WIDTH-1:0];
  assign a_neg = a_raw[IN_WIDTH-1];
  assign b_neg = b_raw[IN_WIDTH-1];
  // The most negative value maps to 2^(IN_WIDTH-1), which still fits unsigned.
  assign a_abs = a_neg ? (~a_raw + 1'b1) : a_raw;
  assign b_abs = b_neg ? (~b_raw + 1'b1) : b_raw;
  assign r_neg = (a_abs >= b_abs) ? a_neg : b_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1.valid <= 1'b0;
      ctl2.valid <= 1'b0;
      ctl.valid  <= 1'b0;
    end else if (en) begin
      ctl1.valid <= take;
      ctl2.valid <= ctl1.valid;
      ctl.valid  <= ctl2.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl1.zero  <= (a_abs == '0) && (b_abs == '0);
      ctl1.c_neg <= a_neg != r_neg;
      ctl1.s_neg <= b_neg != r_neg;
      a_mag      <= a_abs;
      b_mag      <= b_abs;
      ctl2.zero  <= ctl1.zero;
      ctl2.c_neg <= ctl1.c_neg;
      ctl2.s_neg <= ctl1.s_neg;
      a_sq       <= SW'(a_mag) * SW'(a_mag);
      b_sq       <= SW'(b_mag) * SW'(b_mag);
      ctl.zero   <= ctl2.zero;
      ctl.c_neg  <= ctl2.c_neg;
      ctl.s_neg  <= ctl2.s_neg;
      sum        <= a_sq + b_sq;
      rem_c      <= RW'(a_sq) << (2 * FRAC_BITS);
      rem_s      <= RW'(b_sq) << (2 * FRAC_BITS);
    end
  end

endmodule

[design/grg_cell.sv]
// One cell of the root chain: settles one bit of both the cosine and sine magnitudes.
// Depends on grg_pkg.
`timescale 1ns / 1ps

module grg_cell import grg_pkg::*; #(
  parameter int IN_WIDTH  = IN_WIDTH_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int BIT       = FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  ctl_t                                   prev_ctl,
  input  logic [2*IN_WIDTH-1:0]                  prev_sum,
  input  logic [2*IN_WIDTH+2*FRAC_BITS+1:0]      prev_rem_c,
  input  logic [2*IN_WIDTH+FRAC_BITS:0]          prev_prod_c,
  input  logic [FRAC_BITS:0]                     prev_k_c,
  input  logic [2*IN_WIDTH+2*FRAC_BITS+1:0]      prev_rem_s,
  input  logic [2*IN_WIDTH+FRAC_BITS:0]          prev_prod_s,
  input  logic [FRAC_BITS:0]                     prev_k_s,
  output ctl_t                                   ctl,
  output logic [2*IN_WIDTH-1:0]                  sum,
  output logic [2*IN_WIDTH+2*FRAC_BITS+1:0]      rem_c,
  output logic [2*IN_WIDTH+FRAC_BITS:0]          prod_c,
  output logic [FRAC_BITS:0]                     k_c,
  output logic [2*IN_WIDTH+2*FRAC_BITS+1:0]      rem_s,
  output logic [2*IN_WIDTH+FRAC_BITS:0]          prod_s,
  output logic [FRAC_BITS:0]                     k_s
);

  localparam int SW = 2 * IN_WIDTH;
  localparam int RW = SW + 2 * FRAC_BITS + 2;
  localparam int PW = SW + FRAC_BITS + 1;
  localparam int KW = FRAC_BITS + 1;

  // Setting this bit raises k*k*S by (k*2^(BIT+1) + 2^(2*BIT))*S; prod holds k*S.
  logic [RW-1:0] sq_term, d_c, d_s;
  logic          fit_c, fit_s;

  assign sq_term = RW'(prev_sum) << (2 * BIT);
  assign d_c     = (RW'(prev_prod_c) << (BIT + 1)) + sq_term;
  assign d_s     = (RW'(prev_prod_s) << (BIT + 1)) + sq_term;
  assign fit_c   = d_c <= prev_rem_c;
  assign fit_s   = d_s <= prev_rem_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (en) begin
      ctl.valid <= prev_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl.zero  <= prev_ctl.zero;
      ctl.c_neg <= prev_ctl.c_neg;
      ctl.s_neg <= prev_ctl.s_neg;
      sum       <= prev_sum;
      rem_c     <= fit_c ? (prev_rem_c - d_c) : prev_rem_c;
      prod_c    <= fit_c ? (prev_prod_c + (PW'(prev_sum) << BIT)) : prev_prod_c;
      k_c       <= fit_c ? (prev_k_c | (KW'(1) << BIT)) : prev_k_c;
      rem_s     <= fit_s ? (prev_rem_s - d_s) : prev_rem_s;
      prod_s    <= fit_s ? (prev_prod_s + (PW'(prev_sum) << BIT)) : prev_prod_s;
      k_s       <= fit_s ? (prev_k_s | (KW'(1) << BIT)) : prev_k_s;
    end
  end

endmodule

[design/givens_rotation_generate_unit.sv]
// Top level of the Givens rotation generator: front end, chain of root cells, output register.
// Depends on grg_pkg, grg_front, grg_cell and givens_rotation_generate_unit_defines.svh.
`timescale 1ns / 1ps
//
// Channel  | Direction | tdata fields (lowest bit up)      | Handshake
// ---------+-----------+-----------------------------------+-------------------
// s_axis   | in        | in_a [31:0], in_b [63:32]         | s_tvalid/s_tready
// m_axis   | out       | cos_out [31:0], sin_out [63:32]   | m_tvalid/m_tready
//
// The block takes one item per cycle while the output is not stalled and passes each item through
// three front stages (magnitudes, squares, sum), one cell per result bit (FRAC_BITS + 1),
// and the output register. The length of the cell chain sets the latency.
// Reset (rst, synchronous) clears every valid bit; data registers keep their contents.
// The whole pipeline advances together; it stops only while a result sits unclaimed
// at the output, and bubbles inside it are carried along with cleared valid bits.

`include "givens_rotation_generate_unit_defines.svh"

module givens_rotation_generate_unit import grg_pkg::*; #(
  parameter int IN_WIDTH  = IN_WIDTH_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [2*FIELD_W-1:0] s_tdata,   // in_a [31:0], in_b [63:32]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [2*FIELD_W-1:0] m_tdata    // cos_out [31:0], sin_out [63:32]
);

  localparam int SW     = 2 * IN_WIDTH;
  localparam int RW     = SW + 2 * FRAC_BITS + 2;
  localparam int PW     = SW + FRAC_BITS + 1;
  localparam int KW     = FRAC_BITS + 1;
  localparam int NCELLS = FRAC_BITS + 1;

  // The pipeline moves whenever the output register is empty or being drained.
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Stage signals of the cell chain; index 0 is the front end's output.
  ctl_t          st_ctl   [NCELLS+1];
  logic [SW-1:0] st_sum   [NCELLS+1];
  logic [RW-1:0] st_rem_c [NCELLS+1];
  logic [PW-1:0] st_prod_c[NCELLS+1];
  logic [KW-1:0] st_k_c   [NCELLS+1];
  logic [RW-1:0] st_rem_s [NCELLS+1];
  logic [PW-1:0] st_prod_s[NCELLS+1];
  logic [KW-1:0] st_k_s   [NCELLS+1];

  grg_front #(
    .IN_WIDTH (IN_WIDTH),
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .take (s_tvalid),
    .in_a (s_tdata[FIELD_W-1:0]),
    .in_b (s_tdata[2*FIELD_W-1:FIELD_W]),
    .ctl  (st_ctl[0]),
    .sum  (st_sum[0]),
    .rem_c(st_rem_c[0]),
    .rem_s(st_rem_s[0])
  );

  // Every root starts from k = 0, so k*S starts at zero as well.
  assign st_prod_c[0] = '0;
  assign st_k_c[0]    = '0;
  assign st_prod_s[0] = '0;
  assign st_k_s[0]    = '0;

  // Cell j decides bit FRAC_BITS - j, from the top bit down.
  for (genvar j = 0; j < NCELLS; j++) begin : g_cell
    grg_cell #(
      .IN_WIDTH (IN_WIDTH),
      .FRAC_BITS(FRAC_BITS),
      .BIT      (FRAC_BITS - j)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .prev_ctl   (st_ctl[j]),
      .prev_sum   (st_sum[j]),
      .prev_rem_c (st_rem_c[j]),
      .prev_prod_c(st_prod_c[j]),
      .prev_k_c   (st_k_c[j]),
      .prev_rem_s (st_rem_s[j]),
      .prev_prod_s(st_prod_s[j]),
      .prev_k_s   (st_k_s[j]),
      .ctl        (st_ctl[j+1]),
      .sum        (st_sum[j+1]),
      .rem_c      (st_rem_c[j+1]),
      .prod_c     (st_prod_c[j+1]),
      .k_c        (st_k_c[j+1]),
      .rem_s      (st_rem_s[j+1]),
      .prod_s     (st_prod_s[j+1]),
      .k_s        (st_k_s[j+1])
    );
  end

  // Output stage: apply the signs, and give c = 1.0, s = 0 when both inputs are zero.
  ctl_t               fin;
  logic [FIELD_W-1:0] c_mag, s_mag, c_val, s_val, one_val;

  assign fin     = st_ctl[NCELLS];
  assign c_mag   = FIELD_W'(st_k_c[NCELLS]);
  assign s_mag   = FIELD_W'(st_k_s[NCELLS]);
  assign one_val = FIELD_W'(1) << FRAC_BITS;
  assign c_val   = fin.zero ? one_val : (fin.c_neg ? (~c_mag + 1'b1) : c_mag);
  assign s_val   = fin.zero ? '0 : (fin.s_neg ? (~s_mag + 1'b1) : s_mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= fin.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {s_val, c_val};
    end
  end

  // Range flags of the held result, as signed Q(FIELD_W-FRAC_BITS).FRAC_BITS values.
  logic signed [FIELD_W-1:0] cos_res, sin_res, one_s;
  logic                      cos_ok, sin_ok;

  assign cos_res = m_tdata[FIELD_W-1:0];
  assign sin_res = m_tdata[2*FIELD_W-1:FIELD_W];
  assign one_s   = one_val;
  assign cos_ok  = (cos_res <= one_s) && (cos_res >= -one_s);
  assign sin_ok  = (sin_res <= one_s) && (sin_res >= -one_s);

  // A result never exceeds 1.0 in magnitude.
  `GRG_ASSERT_IMPL(a_cos_range, m_tvalid, cos_ok, "cosine out of range")
  `GRG_ASSERT_IMPL(a_sin_range, m_tvalid, sin_ok, "sine out of range")
  // Input is taken exactly when the pipeline advances.
  `GRG_ASSERT_ALWAYS(a_ready_rule, (s_tready === (!m_tvalid || m_tready)), "ready mismatch")
  // No result shows right after reset.
  `GRG_ASSERT_ALWAYS(a_reset_clear, (rst |=> !m_tvalid), "result valid after reset")

endmodule
